// ===== rtl/altitude_velocity_kalman_step_macros.svh =====
// assertion macros used by the checker file
`ifndef ALTITUDE_VELOCITY_KALMAN_STEP_MACROS_SVH
`define ALTITUDE_VELOCITY_KALMAN_STEP_MACROS_SVH

// same-cycle implication, disabled in reset
`define AVKS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("avks check failed");

// next-cycle implication, disabled in reset
`define AVKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("avks check failed");

// next-cycle implication that also holds across reset
`define AVKS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("avks check failed");

`endif

// ===== rtl/avks_pkg.sv =====
`default_nettype none
package avks_pkg;

  localparam int STATE_FRAC_BITS = 16;
  localparam int COV_FRAC_BITS   = 40;
  localparam int CFG_W           = 47;
  localparam int IDX_W           = 3;

  // multiplier operand and result
  typedef logic signed [49:0] mop_t;
  typedef logic signed [57:0] mres_t;

  typedef enum logic [1:0] {
    SH_16,
    SH_32,
    SH_33,
    SH_COV
  } shift_t;

  typedef struct packed {
    logic   start;
    shift_t shift;
  } mul_req_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_Q_ALT         = 3'd1,
    REG_Q_CROSS       = 3'd2,
    REG_Q_VEL         = 3'd3,
    REG_R_MEAS        = 3'd4,
    REG_STILL_ALT     = 3'd5,
    REG_STILL_ACC     = 3'd6,
    REG_DAMP_FACTOR   = 3'd7
  } reg_idx_t;

  localparam logic [56:0] LIMP = 57'(1) << 56;
  localparam logic [47:0] LIM48 = 48'h7FFF_FFFF_FFFF;
  localparam logic signed [47:0] COV_RESET = 48'(10) << COV_FRAC_BITS;

  localparam logic signed [59:0] MAX32_W = 60'sd2147483647;
  localparam logic signed [59:0] MIN32_W = -60'sd2147483648;
  localparam logic signed [59:0] MAX48_W = 60'sd140737488355327;
  localparam logic signed [59:0] MIN48_W = -60'sd140737488355328;

  function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
    if (v > MAX32_W) return MAX32_W[31:0];
    if (v < MIN32_W) return MIN32_W[31:0];
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [59:0] v);
    if (v > MAX48_W) return MAX48_W[47:0];
    if (v < MIN48_W) return MIN48_W[47:0];
    return v[47:0];
  endfunction

  function automatic logic [49:0] mag50(input logic signed [49:0] v);
    return v[49] ? 50'(-v) : 50'(v);
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/altitude_velocity_kalman_step.sv =====
// two-state altitude / velocity kalman filter, one step per sample
// input channel: in_valid / in_ready request carrying vert_accel and baro_alt,
//   both signed q16.16; a request is taken when both are high
// output channel: out_valid / out_ready request carrying alt_est and vel_est,
//   signed q16.16, one result per input request
// config: cfg_wr_en, cfg_index, cfg_data; the user must write it only while
//   the block is idle, the block itself does not enforce this
// sequence: 13 multiplies (14 when the velocity is damped) on the shared
//   50x16 digit multiplier, two gain divides on the bit-serial divider
//   (ending early when the gain saturates), then a commit
// throughput: one sample at a time; in_ready is high only while idle
// the finished result sits in an output register; if the receiver stalls,
//   the next request can still be taken and the block holds its new result
//   until the old one has been taken
// reset: clears the filter state (covariance diagonals to 10.0), loads the
//   default register values and empties the output register
`default_nettype none
module altitude_velocity_kalman_step (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [avks_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [avks_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [31:0]              vert_accel,
  input  wire logic signed [31:0]              baro_alt,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [31:0]                   alt_est,
  output logic signed [31:0]                   vel_est
);
  import avks_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MSTART = 6'b000010,
    ST_MWAIT  = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DWAIT  = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  // multiply steps of one filter update, in issue order
  typedef enum logic [3:0] {
    OP_T2, OP_VP, OP_VT, OP_AT2, OP_PX, OP_PVV, OP_PVT,
    OP_K0E, OP_K1E, OP_CAA, OP_CAV, OP_CVA, OP_CVV, OP_DAMP
  } op_t;

  // configuration registers
  logic [31:0] sample_period;
  logic [46:0] q_alt;
  logic [46:0] q_cross;
  logic [46:0] q_vel;
  logic [46:0] r_meas;
  logic [30:0] still_alt_threshold;
  logic [30:0] still_acc_threshold;
  logic [15:0] damp_factor;

  // filter state
  logic signed [31:0] alt_state;
  logic signed [31:0] vel_state;
  logic signed [47:0] cov_aa;
  logic signed [47:0] cov_av;
  logic signed [47:0] cov_va;
  logic signed [47:0] cov_vv;

  // per-sample working registers
  state_t             state;
  op_t                op;
  logic               dsel;
  logic signed [31:0] accel_r;
  logic signed [31:0] baro_r;
  logic [31:0]        t2;
  logic signed [59:0] tmp;
  logic signed [31:0] vp;
  logic signed [31:0] ap;
  logic signed [47:0] paa;
  logic signed [47:0] pav;
  logic signed [47:0] pva;
  logic signed [47:0] pvv;
  logic signed [47:0] k0;
  logic signed [47:0] k1;
  logic signed [31:0] alt_new;
  logic signed [31:0] vel_new;

  // shared units
  mul_req_t           mreq;
  mop_t               ma;
  mop_t               mb;
  logic               mdone;
  mres_t              mres;
  logic signed [59:0] r60;
  logic               dstart;
  logic signed [47:0] dnum;
  logic [47:0]        dden;
  logic               ddone;
  logic signed [47:0] dquo;

  logic signed [49:0] lsum;
  logic signed [33:0] innov;
  logic signed [33:0] dalt;
  logic signed [33:0] acc_x;
  logic [33:0]        dalt_mag;
  logic [33:0]        acc_mag;
  logic               still;

  assign in_ready = (state == ST_IDLE);
  assign r60      = 60'(mres);

  // innovation and stationary detection
  assign innov    = 34'(baro_r) - 34'(ap);
  assign dalt     = 34'(alt_new) - 34'(alt_state);
  assign acc_x    = 34'(accel_r);
  assign dalt_mag = dalt[33] ? 34'(-dalt) : 34'(dalt);
  assign acc_mag  = acc_x[33] ? 34'(-acc_x) : 34'(acc_x);
  assign still    = (dalt_mag < 34'(still_alt_threshold)) &&
                    (acc_mag < 34'(still_acc_threshold));

  // innovation variance, clamped to one lsb
  assign lsum   = 50'(paa) + 50'(r_meas);
  assign dden   = (lsum < 50'sd1) ? 48'd1 : lsum[47:0];
  assign dnum   = dsel ? pva : paa;
  assign dstart = (state == ST_DSTART);

  // operand select for the shared multiplier
  always_comb begin
    mreq.start = (state == ST_MSTART);
    mreq.shift = SH_32;
    ma         = '0;
    mb         = '0;
    case (op)
      OP_T2: begin
        ma = 50'(sample_period);
        mb = 50'(sample_period);
      end
      OP_VP: begin
        ma = 50'(accel_r);
        mb = 50'(sample_period);
      end
      OP_VT: begin
        ma = 50'(vel_state);
        mb = 50'(sample_period);
      end
      OP_AT2: begin
        ma         = 50'(accel_r);
        mb         = 50'(t2);
        mreq.shift = SH_33;
      end
      OP_PX: begin
        ma = 50'(cov_av) + 50'(cov_va);
        mb = 50'(sample_period);
      end
      OP_PVV: begin
        ma = 50'(cov_vv);
        mb = 50'(t2);
      end
      OP_PVT: begin
        ma = 50'(cov_vv);
        mb = 50'(sample_period);
      end
      OP_K0E: begin
        ma         = 50'(k0);
        mb         = 50'(innov);
        mreq.shift = SH_COV;
      end
      OP_K1E: begin
        ma         = 50'(k1);
        mb         = 50'(innov);
        mreq.shift = SH_COV;
      end
      OP_CAA: begin
        ma         = 50'(k0);
        mb         = 50'(paa);
        mreq.shift = SH_COV;
      end
      OP_CAV: begin
        ma         = 50'(k0);
        mb         = 50'(pav);
        mreq.shift = SH_COV;
      end
      OP_CVA: begin
        ma         = 50'(k1);
        mb         = 50'(paa);
        mreq.shift = SH_COV;
      end
      OP_CVV: begin
        ma         = 50'(k1);
        mb         = 50'(pav);
        mreq.shift = SH_COV;
      end
      OP_DAMP: begin
        ma         = 50'(vel_new);
        mb         = 50'(damp_factor);
        mreq.shift = SH_16;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  avks_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (ma),
    .b    (mb),
    .done (mdone),
    .res  (mres)
  );

  avks_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quo   (dquo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period       <= 32'd17179869;
      q_alt               <= 47'd281;
      q_cross             <= 47'd140737;
      q_vel               <= 47'd70368744;
      r_meas              <= 47'd43980465111;
      still_alt_threshold <= 31'd1311;
      still_acc_threshold <= 31'd32768;
      damp_factor         <= 16'd62259;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_SAMPLE_PERIOD: sample_period       <= cfg_data[31:0];
        REG_Q_ALT:         q_alt               <= cfg_data;
        REG_Q_CROSS:       q_cross             <= cfg_data;
        REG_Q_VEL:         q_vel               <= cfg_data;
        REG_R_MEAS:        r_meas              <= cfg_data;
        REG_STILL_ALT:     still_alt_threshold <= cfg_data[30:0];
        REG_STILL_ACC:     still_acc_threshold <= cfg_data[30:0];
        REG_DAMP_FACTOR:   damp_factor         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_T2;
      dsel      <= 1'b0;
      out_valid <= 1'b0;
      alt_state <= '0;
      vel_state <= '0;
      cov_aa    <= COV_RESET;
      cov_av    <= '0;
      cov_va    <= '0;
      cov_vv    <= COV_RESET;
    end else begin
      // load a new result when the register is free or being emptied
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            accel_r <= vert_accel;
            baro_r  <= baro_alt;
            op      <= OP_T2;
            state   <= ST_MSTART;
          end
        end
        ST_MSTART: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mdone) begin
            op <= op_t'(op + 4'd1);
            if (op == OP_PVT) begin
              state <= ST_DSTART;
            end else if (op == OP_DAMP || (op == OP_CVV && !still)) begin
              // damp the velocity only when nearly stationary
              state <= ST_OUT;
            end else begin
              state <= ST_MSTART;
            end
            case (op)
              OP_T2:  t2  <= mres[31:0];
              OP_VP:  vp  <= sat32(60'(vel_state) + r60);
              OP_VT:  tmp <= r60;
              OP_AT2: ap  <= sat32(60'(alt_state) + tmp + r60);
              OP_PX:  tmp <= r60;
              OP_PVV: paa <= sat48(60'(cov_aa) + tmp + r60 + 60'(q_alt));
              OP_PVT: begin
                // predicted cross terms share the same t * cov_vv product
                pav  <= sat48(60'(cov_av) + r60 + 60'(q_cross));
                pva  <= sat48(60'(cov_va) + r60 + 60'(q_cross));
                pvv  <= sat48(60'(cov_vv) + 60'(q_vel));
                dsel <= 1'b0;
              end
              OP_K0E:  alt_new <= sat32(60'(ap) + r60);
              OP_K1E:  vel_new <= sat32(60'(vp) + r60);
              OP_CAA:  cov_aa  <= sat48(60'(paa) - r60);
              OP_CAV:  cov_av  <= sat48(60'(pav) - r60);
              OP_CVA:  cov_va  <= sat48(60'(pva) - r60);
              OP_CVV:  cov_vv  <= sat48(60'(pvv) - r60);
              OP_DAMP: vel_new <= mres[31:0];
              default: ;
            endcase
          end
        end
        ST_DSTART: begin
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (ddone) begin
            if (!dsel) begin
              k0    <= dquo;
              dsel  <= 1'b1;
              state <= ST_DSTART;
            end else begin
              k1    <= dquo;
              op    <= OP_K0E;
              state <= ST_MSTART;
            end
          end
        end
        ST_OUT: begin
          // wait for the output register to be free, then commit
          if (!out_valid || out_ready) begin
            alt_est   <= alt_new;
            vel_est   <= vel_new;
            alt_state <= alt_new;
            vel_state <= vel_new;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/avks_mul.sv =====
`default_nettype none
// sign-magnitude multiplier, one 16-bit digit of b per cycle, then shift and clip
module avks_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire avks_pkg::mul_req_t req,
  input  wire avks_pkg::mop_t    a,
  input  wire avks_pkg::mop_t    b,
  output logic                   done,
  output avks_pkg::mres_t        res
);
  import avks_pkg::*;

  logic [49:0]  xm;
  logic [63:0]  ym;
  logic [99:0]  acc;
  logic         neg;
  shift_t       sh;
  logic [1:0]   cnt;
  logic         busy;
  logic         post;
  logic [65:0]  prod;
  logic [99:0]  shifted;
  logic [56:0]  clipped;
  mres_t        mres;

  assign prod = xm * ym[63:48];

  always_comb begin
    case (sh)
      SH_16:   shifted = acc >> 16;
      SH_32:   shifted = acc >> 32;
      SH_33:   shifted = acc >> 33;
      SH_COV:  shifted = acc >> COV_FRAC_BITS;
      default: shifted = acc;
    endcase
    clipped = (shifted > 100'(LIMP)) ? LIMP : shifted[56:0];
    mres    = mres_t'({1'b0, clipped});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      post <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        xm   <= mag50(a);
        ym   <= {14'b0, mag50(b)};
        acc  <= '0;
        neg  <= a[49] ^ b[49];
        sh   <= req.shift;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= {acc[83:0], 16'b0} + 100'(prod);
        ym  <= {ym[47:0], 16'b0};
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          post <= 1'b1;
        end
      end else if (post) begin
        post <= 1'b0;
        done <= 1'b1;
        res  <= neg ? -mres : mres;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/avks_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle, quotient in cov fraction format
module avks_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [47:0] num,
  input  wire logic [47:0]        den,
  output logic                    done,
  output logic signed [47:0]      quo
);
  import avks_pkg::*;

  logic [47:0] n_mag;
  logic [47:0] r;
  logic [47:0] d;
  logic [47:0] q;
  logic [COV_FRAC_BITS-33:0] nb;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic        post;
  logic [48:0] rs;
  logic        ge;
  logic [47:0] qmag;

  assign n_mag = mag48(num);
  assign rs    = {r, nb[COV_FRAC_BITS-33]};
  assign ge    = rs >= {1'b0, d};
  assign qmag  = q[47] ? LIM48 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      post <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[47];
        d   <= den;
        // quotient would not fit: saturate right away
        if ({8'b0, n_mag} >= {den, 8'b0}) begin
          q    <= '1;
          post <= 1'b1;
        end else begin
          r    <= 48'(n_mag >> 8);
          nb   <= n_mag[7:0];
          q    <= '0;
          cnt  <= 6'd47;
          busy <= 1'b1;
        end
      end else if (busy) begin
        r   <= ge ? 48'(rs - {1'b0, d}) : rs[47:0];
        nb  <= {nb[COV_FRAC_BITS-34:0], 1'b0};
        q   <= {q[46:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          post <= 1'b1;
        end
      end else if (post) begin
        post <= 1'b0;
        done <= 1'b1;
        quo  <= neg ? -$signed(qmag) : $signed(qmag);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/avks_checker.sv =====
`default_nettype none
`include "altitude_velocity_kalman_step_macros.svh"
module avks_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] alt_est,
  input wire logic signed [31:0] vel_est
);

  // a stalled result holds
  `AVKS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(alt_est) && $stable(vel_est))

  // in_ready drops once a request is taken
  `AVKS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // two requests are never taken back to back
  `AVKS_ASSERT_NOW(a_no_double_accept, clk, rst, in_valid && in_ready, !$past(in_valid && in_ready))

  // reset leaves the block idle with no result pending
  `AVKS_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, in_ready && !out_valid)

endmodule

bind altitude_velocity_kalman_step avks_checker u_avks_checker (.*);
`default_nettype wire
